// File: rtl/bs_pkg.sv
// Package for the bilinear sampler: store geometry, derived widths and
// configuration register indexes. No dependencies.
`default_nettype none
package bs_pkg;
	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int CFG_W      = 9;
	localparam int SZ_W       = ($clog2(MAX_DIM + 1) > CFG_W) ? $clog2(MAX_DIM + 1) : CFG_W;
	localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(DEPTH);
	localparam int XW         = $clog2(MAX_WIDTH);
	localparam int YW         = $clog2(MAX_HEIGHT);
	localparam int PIX_W      = 16;
	localparam int CRD_W      = 17;
	localparam int FRAC_W     = 16;
	localparam int SCL_W      = CRD_W + SZ_W;
	localparam int CIDX_W     = 2;

	localparam logic [CIDX_W-1:0] REG_IMAGE_WIDTH  = CIDX_W'(0);
	localparam logic [CIDX_W-1:0] REG_IMAGE_HEIGHT = CIDX_W'(1);

	localparam logic [CFG_W-1:0] IMAGE_SIZE_RST = CFG_W'(256);
endpackage
`default_nettype wire

// File: rtl/bs_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`default_nettype none
module bs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

// File: rtl/bilinear_sampler_16bit.sv
// Bilinear sampler over a 16-bit grayscale image held in one RAM.
// Depends on bs_pkg and bs_ram.
//
// Usage:
//  - Command channel: a word is taken at a rising edge with start high and
//    busy low. mode 0 writes pixel_value at (pixel_x, pixel_y); mode 1 asks
//    for a sample at (coord_u, coord_v), unsigned Q1.16.
//  - A write gives no result; busy stays low, so writes can be issued every
//    cycle.
//  - A sample gives one result word: sample_value and in_range for one cycle
//    with done high. Out of range, done follows ST_MUL (scaling) and
//    ST_CHK (range test); in range, ST_RD then fetches the neighbors with
//    four reads on the single RAM port, ST_CAP takes the last read data, and
//    ST_LX, ST_LY interpolate one axis each. busy is high until done.
//  - The receiver cannot stall; a result is shown for exactly one cycle.
//  - Config channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
//    index 0 is image_width, 1 image_height, others are ignored.
//    cfg_ready is always high; write only while idle.
//  - Reset (arst_n low) returns to idle and sets both sizes to 256. The
//    image RAM is not cleared; unwritten pixels read undefined data.
`default_nettype none
module bilinear_sampler_16bit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          mode,
	input  wire logic [7:0]                    pixel_x,
	input  wire logic [7:0]                    pixel_y,
	input  wire logic [bs_pkg::PIX_W-1:0]      pixel_value,
	input  wire logic [bs_pkg::CRD_W-1:0]      coord_u,
	input  wire logic [bs_pkg::CRD_W-1:0]      coord_v,
	output logic                               done,
	output logic [bs_pkg::PIX_W-1:0]           sample_value,
	output logic                               in_range,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [bs_pkg::CIDX_W-1:0]     cfg_index,
	input  wire logic [bs_pkg::CFG_W-1:0]      cfg_data
);
	localparam int SZ_W   = bs_pkg::SZ_W;
	localparam int ADDR_W = bs_pkg::ADDR_W;
	localparam int PIX_W  = bs_pkg::PIX_W;
	localparam int FRAC_W = bs_pkg::FRAC_W;
	localparam int SCL_W  = bs_pkg::SCL_W;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_CHK  = 7'b0000100,
		ST_RD   = 7'b0001000,
		ST_CAP  = 7'b0010000,
		ST_LX   = 7'b0100000,
		ST_LY   = 7'b1000000
	} state_t;

	state_t state_q;

	logic [bs_pkg::CFG_W-1:0] image_width_q, image_height_q;
	logic [bs_pkg::CRD_W-1:0] u_q, v_q;
	logic [SCL_W-1:0]         su_q, sv_q;
	logic                     small_q;
	logic [FRAC_W-1:0]        fu_q, fv_q;
	logic [ADDR_W-1:0]        base_q;
	logic [1:0]               rd_cnt_q;
	logic                     cap_q;
	logic [1:0]               cap_idx_q;
	logic [PIX_W-1:0]         pix_q [4];
	logic [31:0]              a_q, b_q;
	logic                     done_q, in_range_q;
	logic [PIX_W-1:0]         sample_q;

	logic [SZ_W-1:0]   w_eff, h_eff, wm1, hm1;
	logic [SZ_W:0]     cellx, celly;
	logic              out_of_range;
	logic [ADDR_W-1:0] base_d;
	logic              accept, wr_ok, ram_we;
	logic [ADDR_W-1:0] wr_addr, rd_addr, ram_addr;
	logic [PIX_W-1:0]  ram_rdata;

	logic signed [PIX_W:0]        dx0, dx1;
	logic signed [FRAC_W:0]       fu_s, fv_s;
	logic signed [2*PIX_W+1:0]    px0, px1, ax, bx;
	logic signed [32:0]           dy;
	logic signed [49:0]           py, ry;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	always_comb begin
		w_eff = (SZ_W'(image_width_q) > SZ_W'(bs_pkg::MAX_WIDTH)) ?
			SZ_W'(bs_pkg::MAX_WIDTH) : SZ_W'(image_width_q);
		h_eff = (SZ_W'(image_height_q) > SZ_W'(bs_pkg::MAX_HEIGHT)) ?
			SZ_W'(bs_pkg::MAX_HEIGHT) : SZ_W'(image_height_q);
		wm1 = w_eff - SZ_W'(1);
		hm1 = h_eff - SZ_W'(1);
		cellx = su_q[FRAC_W +: SZ_W+1];
		celly = sv_q[FRAC_W +: SZ_W+1];
		out_of_range = small_q || (cellx >= {1'b0, wm1}) || (celly >= {1'b0, hm1});
		base_d = ADDR_W'(celly[bs_pkg::YW-1:0]) * ADDR_W'(bs_pkg::MAX_WIDTH)
			+ ADDR_W'(cellx[bs_pkg::XW-1:0]);
	end

	// RAM port: writes only when idle, neighbor reads only in ST_RD
	always_comb begin
		wr_ok = (32'(pixel_x) < bs_pkg::MAX_WIDTH) && (32'(pixel_y) < bs_pkg::MAX_HEIGHT);
		wr_addr = ADDR_W'(pixel_y) * ADDR_W'(bs_pkg::MAX_WIDTH) + ADDR_W'(pixel_x);
		ram_we = accept && !mode && wr_ok;
		case (rd_cnt_q)
			2'd0:    rd_addr = base_q;
			2'd1:    rd_addr = base_q + ADDR_W'(1);
			2'd2:    rd_addr = base_q + ADDR_W'(bs_pkg::MAX_WIDTH);
			default: rd_addr = base_q + ADDR_W'(bs_pkg::MAX_WIDTH + 1);
		endcase
		ram_addr = busy ? rd_addr : wr_addr;
	end

	bs_ram #(
		.WIDTH(PIX_W),
		.DEPTH(bs_pkg::DEPTH)
	) u_image (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(pixel_value),
		.rdata(ram_rdata)
	);

	// a = p00*2^16 + (p10-p00)*fu ; r = a*2^16 + (b-a)*fv
	always_comb begin
		fu_s = $signed({1'b0, fu_q});
		fv_s = $signed({1'b0, fv_q});
		dx0  = $signed({1'b0, pix_q[1]}) - $signed({1'b0, pix_q[0]});
		dx1  = $signed({1'b0, pix_q[3]}) - $signed({1'b0, pix_q[2]});
		px0  = dx0 * fu_s;
		px1  = dx1 * fu_s;
		ax   = $signed({2'b00, pix_q[0], 16'h0000}) + px0;
		bx   = $signed({2'b00, pix_q[2], 16'h0000}) + px1;
		dy   = $signed({1'b0, b_q}) - $signed({1'b0, a_q});
		py   = dy * fv_s;
		ry   = $signed({2'b00, a_q, 16'h0000}) + py;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= bs_pkg::IMAGE_SIZE_RST;
			image_height_q <= bs_pkg::IMAGE_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bs_pkg::REG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				bs_pkg::REG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_cnt_q <= 2'd0;
			cap_q    <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			cap_q  <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && mode) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					rd_cnt_q <= 2'd0;
					if (out_of_range) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					cap_q    <= 1'b1;
					rd_cnt_q <= rd_cnt_q + 2'd1;
					if (rd_cnt_q == 2'd3) begin
						state_q <= ST_CAP;
					end
				end
				ST_CAP: begin
					state_q <= ST_LX;
				end
				ST_LX: begin
					state_q <= ST_LY;
				end
				ST_LY: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && mode) begin
			u_q <= coord_u;
			v_q <= coord_v;
		end
		if (state_q == ST_MUL) begin
			su_q    <= SCL_W'(u_q) * SCL_W'(wm1);
			sv_q    <= SCL_W'(v_q) * SCL_W'(hm1);
			small_q <= (w_eff < SZ_W'(2)) || (h_eff < SZ_W'(2));
		end
		if (state_q == ST_CHK) begin
			base_q     <= base_d;
			fu_q       <= su_q[FRAC_W-1:0];
			fv_q       <= sv_q[FRAC_W-1:0];
			sample_q   <= '0;
			in_range_q <= 1'b0;
		end
		if (state_q == ST_RD) begin
			cap_idx_q <= rd_cnt_q;
		end
		if (cap_q) begin
			pix_q[cap_idx_q] <= ram_rdata;
		end
		if (state_q == ST_LX) begin
			a_q <= ax[31:0];
			b_q <= bx[31:0];
		end
		if (state_q == ST_LY) begin
			sample_q   <= ry[47:32];
			in_range_q <= 1'b1;
		end
	end

	assign done         = done_q;
	assign sample_value = sample_q;
	assign in_range     = in_range_q;
endmodule
`default_nettype wire
